@@ sv/keyframe_linear_interpolator_assert.svh @@
// assertion macros for the keyframe interpolator
`ifndef KEYFRAME_LINEAR_INTERPOLATOR_ASSERT_SVH
`define KEYFRAME_LINEAR_INTERPOLATOR_ASSERT_SVH

// same-cycle implication, disabled during reset
`define KLI_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define KLI_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/kli_pkg.sv @@
package kli_pkg;

  // word and row geometry
  localparam int unsigned DATA_W         = 32;
  localparam int unsigned NUM_COLS       = 6;
  localparam int unsigned STRIDE_W       = 6;
  localparam int unsigned MAX_STRIDE_DEF = 32;
  localparam logic [STRIDE_W-1:0] STRIDE_RESET = 6'd4;

  typedef logic [NUM_COLS-1:0][DATA_W-1:0] row_t;

  // control sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_INTERP,
    ST_FLUSH_KEY,
    ST_FLUSH_RD,
    ST_FLUSH_WR,
    ST_EMIT_ROW
  } kli_state_e;

endpackage

@@ sv/kli_div.sv @@
module kli_div #(
  parameter int unsigned LW = $clog2(kli_pkg::MAX_STRIDE_DEF + 1)
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [kli_pkg::DATA_W:0]    dividend_i,
  input  logic [LW-1:0]               divisor_i,
  output logic                        busy_o,
  output logic [kli_pkg::DATA_W-1:0]  quot_o
);
  import kli_pkg::*;

  localparam int unsigned ITER = DATA_W + 1;
  localparam int unsigned CW   = $clog2(ITER + 1);

  logic              busy_q;
  logic [CW-1:0]     cnt_q;
  logic              neg_q;
  logic [LW-1:0]     div_q;
  logic [LW-1:0]     rem_q;
  logic [DATA_W:0]   quo_q;
  logic [LW:0]       trial;
  logic              fits;
  logic [LW-1:0]     rem_nx;
  logic [DATA_W:0]   mag;
  logic [DATA_W:0]   quo_s;

  // one restoring step per cycle, quotient bits shift in as dividend shifts out
  always_comb begin
    trial  = {rem_q, quo_q[DATA_W]};
    fits   = trial >= {1'b0, div_q};
    rem_nx = fits ? LW'(trial - {1'b0, div_q}) : trial[LW-1:0];
    mag    = dividend_i[DATA_W] ? (~dividend_i + 1'b1) : dividend_i;
    quo_s  = neg_q ? (~quo_q + 1'b1) : quo_q;
  end

  // iteration control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= CW'(ITER);
    end else if (busy_q) begin
      cnt_q <= cnt_q - CW'(1);
      if (cnt_q == CW'(1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      neg_q <= dividend_i[DATA_W];
      div_q <= divisor_i;
      rem_q <= '0;
      quo_q <= mag;
    end else if (busy_q) begin
      rem_q <= rem_nx;
      quo_q <= {quo_q[DATA_W-1:0], fits};
    end
  end

  // truncated toward zero, sign restored
  assign busy_o = busy_q;
  assign quot_o = quo_s[DATA_W-1:0];

endmodule

@@ sv/keyframe_linear_interpolator.sv @@
// Keyframe linear interpolator, rows of six signed Q16.16 columns.
// Input channel: in_valid_i/in_ready_o with col_time_i .. col_e_i and
// end_of_data_i; output channel: out_valid_o/out_ready_i with out_time_o ..
// out_e_o and run_last_o, which marks the last word caused by one input word.
// Configuration: cfg_we_i writes cfg_wdata_i into the stride register.
// A word that opens a segment or is buffered is taken and gives no output. A
// closing keyframe starts five parallel bit-serial dividers, then one
// interpolated word per segment row goes out per cycle unless the output
// stalls. A final word with an open segment flushes the keyframe, then each
// buffered row (memory read, then output register load), then itself.
// Throughput is set by the divider iterations and by the one-port buffer
// memory; the block works on one input word at a time.
// The output register holds a word until taken; the sequencer waits while
// out_valid_o is high and out_ready_i is low, so stalls lose nothing.
// Reset: no segment is open, stride is 4, the output channel is empty; the
// buffer memory needs no clearing pass.
`include "keyframe_linear_interpolator_assert.svh"

module keyframe_linear_interpolator #(
  parameter int unsigned MAX_STRIDE = kli_pkg::MAX_STRIDE_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [kli_pkg::STRIDE_W-1:0]        cfg_wdata_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic signed [kli_pkg::DATA_W-1:0]   col_time_i,
  input  logic signed [kli_pkg::DATA_W-1:0]   col_a_i,
  input  logic signed [kli_pkg::DATA_W-1:0]   col_b_i,
  input  logic signed [kli_pkg::DATA_W-1:0]   col_c_i,
  input  logic signed [kli_pkg::DATA_W-1:0]   col_d_i,
  input  logic signed [kli_pkg::DATA_W-1:0]   col_e_i,
  input  logic                                end_of_data_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [kli_pkg::DATA_W-1:0]   out_time_o,
  output logic signed [kli_pkg::DATA_W-1:0]   out_a_o,
  output logic signed [kli_pkg::DATA_W-1:0]   out_b_o,
  output logic signed [kli_pkg::DATA_W-1:0]   out_c_o,
  output logic signed [kli_pkg::DATA_W-1:0]   out_d_o,
  output logic signed [kli_pkg::DATA_W-1:0]   out_e_o,
  output logic                                run_last_o
);
  import kli_pkg::*;

  localparam int unsigned LW    = $clog2(MAX_STRIDE + 1);
  localparam int unsigned DEPTH = MAX_STRIDE - 1;
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  kli_state_e            state_q, state_d;
  logic [STRIDE_W-1:0]   stride_q;
  logic                  have_key_q;
  logic [LW-1:0]         row_count_q;
  logic [LW-1:0]         len_q;
  logic [LW-1:0]         k_q;
  row_t                  key_q;
  row_t                  row_q;
  logic                  last_q;
  row_t                  acc_q;
  row_t                  out_row_q;
  logic                  out_last_q;
  logic                  out_valid_q;
  row_t                  mem_rdata_q;
  row_t                  pend_mem [DEPTH];

  row_t                  in_row;
  row_t                  step;
  logic [NUM_COLS-1:0]   div_busy;
  logic                  in_accept;
  logic [LW-1:0]         seg_len;
  logic [LW-1:0]         k_inc;
  logic [STRIDE_W-1:0]   eff_stride;
  logic                  close_hit;
  logic                  out_free;
  logic                  div_start;
  logic                  mem_we;
  logic                  mem_re;
  logic                  out_load;
  row_t                  out_row_d;
  logic                  out_last_d;
  logic                  interp_load;
  logic                  seg_done;
  logic                  flush_load;
  logic                  emit_done;

  // input row gathering
  assign in_row[0] = col_time_i;
  assign in_row[1] = col_a_i;
  assign in_row[2] = col_b_i;
  assign in_row[3] = col_c_i;
  assign in_row[4] = col_d_i;
  assign in_row[5] = col_e_i;

  // segment bookkeeping
  always_comb begin
    in_accept = in_valid_i && in_ready_o;
    seg_len   = row_count_q + LW'(1);
    k_inc     = k_q + LW'(1);
    if (stride_q == '0) begin
      eff_stride = STRIDE_W'(1);
    end else if (stride_q > STRIDE_W'(MAX_STRIDE)) begin
      eff_stride = STRIDE_W'(MAX_STRIDE);
    end else begin
      eff_stride = stride_q;
    end
    close_hit = have_key_q && (STRIDE_W'(seg_len) >= eff_stride);
    out_free  = !out_valid_q || out_ready_i;
  end

  // one divider lane per interpolated column
  assign step[0]     = '0;
  assign div_busy[0] = 1'b0;
  for (genvar c = 1; c < NUM_COLS; c++) begin : g_lane
    logic [DATA_W:0] diff;
    assign diff = {in_row[c][DATA_W-1], in_row[c]} - {key_q[c][DATA_W-1], key_q[c]};
    kli_div #(
      .LW (LW)
    ) u_div (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .start_i    (div_start),
      .dividend_i (diff),
      .divisor_i  (seg_len),
      .busy_o     (div_busy[c]),
      .quot_o     (step[c])
    );
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          if (!have_key_q) begin
            state_d = end_of_data_i ? ST_EMIT_ROW : ST_IDLE;
          end else if (close_hit) begin
            state_d = ST_DIV;
          end else if (end_of_data_i) begin
            state_d = ST_FLUSH_KEY;
          end
        end
      end
      ST_DIV: begin
        if (~|div_busy) state_d = ST_INTERP;
      end
      ST_INTERP: begin
        if (out_free && (k_inc == len_q)) state_d = last_q ? ST_EMIT_ROW : ST_IDLE;
      end
      ST_FLUSH_KEY: begin
        if (out_free) state_d = (row_count_q == '0) ? ST_EMIT_ROW : ST_FLUSH_RD;
      end
      ST_FLUSH_RD: begin
        state_d = ST_FLUSH_WR;
      end
      ST_FLUSH_WR: begin
        if (out_free) state_d = (k_inc == row_count_q) ? ST_EMIT_ROW : ST_FLUSH_RD;
      end
      ST_EMIT_ROW: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_ready_o  = 1'b0;
    div_start   = 1'b0;
    mem_we      = 1'b0;
    mem_re      = 1'b0;
    out_load    = 1'b0;
    out_row_d   = row_q;
    out_last_d  = 1'b0;
    interp_load = 1'b0;
    flush_load  = 1'b0;
    emit_done   = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        div_start  = in_accept && close_hit;
        mem_we     = in_accept && have_key_q && !close_hit && !end_of_data_i;
      end
      ST_DIV: begin
      end
      ST_INTERP: begin
        out_load    = out_free;
        interp_load = out_free;
        out_row_d   = acc_q;
        out_row_d[0] = key_q[0];
        out_last_d  = (k_inc == len_q) && !last_q;
      end
      ST_FLUSH_KEY: begin
        out_load  = out_free;
        out_row_d = key_q;
      end
      ST_FLUSH_RD: begin
        mem_re = 1'b1;
      end
      ST_FLUSH_WR: begin
        out_load   = out_free;
        flush_load = out_free;
        out_row_d  = mem_rdata_q;
      end
      ST_EMIT_ROW: begin
        out_load   = out_free;
        emit_done  = out_free;
        out_row_d  = row_q;
        out_last_d = 1'b1;
      end
      default: begin
      end
    endcase
    seg_done = interp_load && (k_inc == len_q);
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      stride_q    <= STRIDE_RESET;
      have_key_q  <= 1'b0;
      row_count_q <= '0;
      k_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) stride_q <= cfg_wdata_i;
      if (in_accept && !have_key_q && !end_of_data_i) begin
        have_key_q  <= 1'b1;
        row_count_q <= '0;
      end else if (mem_we) begin
        row_count_q <= seg_len;
      end else if (seg_done && !last_q) begin
        row_count_q <= '0;
      end else if (emit_done) begin
        have_key_q  <= 1'b0;
        row_count_q <= '0;
      end
      if (div_start || (state_q == ST_FLUSH_KEY)) begin
        k_q <= '0;
      end else if (interp_load || flush_load) begin
        k_q <= k_inc;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      row_q  <= in_row;
      last_q <= end_of_data_i;
    end
    if (in_accept && !have_key_q && !end_of_data_i) begin
      key_q <= in_row;
    end else if (seg_done && !last_q) begin
      key_q <= row_q;
    end
    if (div_start) begin
      acc_q <= key_q;
      len_q <= seg_len;
    end else if (interp_load) begin
      for (int c = 0; c < NUM_COLS; c++) begin
        acc_q[c] <= acc_q[c] + step[c];
      end
    end
    if (out_load) begin
      out_row_q  <= out_row_d;
      out_last_q <= out_last_d;
    end
  end

  // buffered rows between keyframes
  always_ff @(posedge clk_i) begin
    if (mem_we) pend_mem[row_count_q[AW-1:0]] <= in_row;
  end

  always_ff @(posedge clk_i) begin
    if (mem_re) mem_rdata_q <= pend_mem[k_q[AW-1:0]];
  end

  // output channel
  assign out_valid_o = out_valid_q;
  assign out_time_o  = out_row_q[0];
  assign out_a_o     = out_row_q[1];
  assign out_b_o     = out_row_q[2];
  assign out_c_o     = out_row_q[3];
  assign out_d_o     = out_row_q[4];
  assign out_e_o     = out_row_q[5];
  assign run_last_o  = out_last_q;

  // checks
  `KLI_ASSERT_NOW(a_div_in_div_state, clk_i, rst_ni, |div_busy, state_q == ST_DIV, "divider busy outside divide state")
  `KLI_ASSERT_NOW(a_no_overwrite, clk_i, rst_ni, out_load, !out_valid_q || out_ready_i, "output word overwritten while stalled")
  `KLI_ASSERT_NOW(a_interp_bound, clk_i, rst_ni, state_q == ST_INTERP, k_q < len_q, "interpolation index past segment length")
  `KLI_ASSERT_NEXT(a_close_divides, clk_i, rst_ni, in_accept && close_hit, state_q == ST_DIV, "closing keyframe did not start division")

endmodule

@@ dv/keyframe_linear_interpolator_tb.sv @@
`timescale 1ns / 1ps

module keyframe_linear_interpolator_tb;
  import kli_pkg::*;

  localparam logic [DATA_W-1:0] WORD_MAX = 32'h7FFF_FFFF;
  localparam logic [DATA_W-1:0] WORD_MIN = 32'h8000_0000;
  localparam int SETTLE_CYCLES = 40;
  localparam int STUCK_LIMIT = 1000;

  typedef struct {
    row_t cols;
    logic last;
  } out_word_t;

  logic                       clk_i;
  logic                       rst_ni;
  logic                       cfg_we_i;
  logic [STRIDE_W-1:0]        cfg_wdata_i;
  logic                       in_valid_i;
  logic                       in_ready_o;
  logic signed [DATA_W-1:0]   col_time_i, col_a_i, col_b_i, col_c_i, col_d_i, col_e_i;
  logic                       end_of_data_i;
  logic                       out_valid_o;
  logic                       out_ready_i;
  logic signed [DATA_W-1:0]   out_time_o, out_a_o, out_b_o, out_c_o, out_d_o, out_e_o;
  logic                       run_last_o;

  keyframe_linear_interpolator dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .col_time_i    (col_time_i),
    .col_a_i       (col_a_i),
    .col_b_i       (col_b_i),
    .col_c_i       (col_c_i),
    .col_d_i       (col_d_i),
    .col_e_i       (col_e_i),
    .end_of_data_i (end_of_data_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .out_time_o    (out_time_o),
    .out_a_o       (out_a_o),
    .out_b_o       (out_b_o),
    .out_c_o       (out_c_o),
    .out_d_o       (out_d_o),
    .out_e_o       (out_e_o),
    .run_last_o    (run_last_o)
  );

  // predictor state
  logic [STRIDE_W-1:0] stride_reg = STRIDE_RESET;
  bit                  have_key = 1'b0;
  row_t                key_cols;
  row_t                pending_rows[$];
  out_word_t           expected_words[$];

  int    mismatch_count = 0;
  int    stuck_cycles = 0;
  int    stall_left = 0;
  bit    no_gaps = 1'b0;
  string col_names[NUM_COLS] = '{"out_time", "out_a", "out_b", "out_c", "out_d", "out_e"};

  // 2 ns clock
  always begin
    clk_i = 1'b0;
    #1;
    clk_i = 1'b1;
    #1;
  end

  function automatic row_t row_of(input logic [DATA_W-1:0] t, a, b, c, d, e);
    row_t row;
    row[0] = t;
    row[1] = a;
    row[2] = b;
    row[3] = c;
    row[4] = d;
    row[5] = e;
    return row;
  endfunction

  function automatic int unsigned active_stride();
    if (stride_reg == 0) return 1;
    if (stride_reg > MAX_STRIDE_DEF) return MAX_STRIDE_DEF;
    return 32'(stride_reg);
  endfunction

  // expected output words for one accepted input word
  function automatic void interpolate_row(input row_t row, input logic last);
    out_word_t   burst[$];
    out_word_t   w;
    longint      slope[NUM_COLS];
    int unsigned seg_len;
    int          c;
    if (!have_key) begin
      if (last) begin
        w.cols = row;
        w.last = 1'b0;
        burst.push_back(w);
      end else begin
        key_cols = row;
        pending_rows.delete();
        have_key = 1'b1;
      end
    end else begin
      seg_len = pending_rows.size() + 1;
      if (seg_len >= active_stride()) begin
        // closing keyframe: linear ramp from the opening keyframe
        for (c = 1; c < NUM_COLS; c++) begin
          slope[c] = (longint'($signed(row[c])) - longint'($signed(key_cols[c])))
                     / longint'(seg_len);
        end
        for (int k = 0; k < seg_len; k++) begin
          w.cols[0] = key_cols[0];
          for (c = 1; c < NUM_COLS; c++) begin
            w.cols[c] = 32'(longint'($signed(key_cols[c])) + longint'(k) * slope[c]);
          end
          w.last = 1'b0;
          burst.push_back(w);
        end
        if (last) begin
          w.cols = row;
          burst.push_back(w);
          have_key = 1'b0;
        end else begin
          key_cols = row;
        end
        pending_rows.delete();
      end else if (last) begin
        // open segment flushed as is
        w.last = 1'b0;
        w.cols = key_cols;
        burst.push_back(w);
        foreach (pending_rows[i]) begin
          w.cols = pending_rows[i];
          burst.push_back(w);
        end
        w.cols = row;
        burst.push_back(w);
        pending_rows.delete();
        have_key = 1'b0;
      end else if (pending_rows.size() < MAX_STRIDE_DEF - 1) begin
        pending_rows.push_back(row);
      end
    end
    if (burst.size() > 0) burst[burst.size()-1].last = 1'b1;
    foreach (burst[i]) expected_words.push_back(burst[i]);
  endfunction

  function automatic int pick_gap();
    int roll;
    if (no_gaps) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [DATA_W-1:0] random_word();
    case ($urandom_range(0, 7))
      0: return WORD_MAX;
      1: return WORD_MIN;
      2: return $urandom_range(0, 32'h0003_FFFF);
      3: return 32'(-int'($urandom_range(0, 32'h0003_FFFF)));
      default: return $urandom();
    endcase
  endfunction

  function automatic row_t random_row();
    return row_of(random_word(), random_word(), random_word(), random_word(),
                  random_word(), random_word());
  endfunction

  // sink side stalls
  always @(posedge clk_i) begin
    if (stall_left > 0) begin
      out_ready_i <= 1'b0;
      stall_left--;
    end else begin
      out_ready_i <= 1'b1;
      stall_left = pick_gap();
    end
  end

  // config tracking, prediction and output checking
  always @(posedge clk_i) begin : monitor
    row_t      got;
    out_word_t want;
    if (rst_ni) begin
      if (cfg_we_i) stride_reg = cfg_wdata_i;
      if (out_valid_o && out_ready_i) begin
        got = row_of(out_time_o, out_a_o, out_b_o, out_c_o, out_d_o, out_e_o);
        if (expected_words.size() == 0) begin
          mismatch_count++;
          $error("output word with none expected");
        end else begin
          want = expected_words.pop_front();
          for (int c = 0; c < NUM_COLS; c++) begin
            if (got[c] !== want.cols[c]) begin
              mismatch_count++;
              $error("%s expected %0d got %0d", col_names[c], $signed(want.cols[c]),
                     $signed(got[c]));
            end
          end
          if (run_last_o !== want.last) begin
            mismatch_count++;
            $error("run_last expected %0d got %0d", want.last, run_last_o);
          end
        end
      end
      if (in_valid_i && in_ready_o) begin
        interpolate_row(row_of(col_time_i, col_a_i, col_b_i, col_c_i, col_d_i, col_e_i),
                        end_of_data_i);
      end
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      stuck_cycles = 0;
    end else begin
      stuck_cycles++;
      if (stuck_cycles >= STUCK_LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  // one input word, valid held until accepted
  task automatic send_row(input row_t row, input logic last);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    col_time_i    <= row[0];
    col_a_i       <= row[1];
    col_b_i       <= row[2];
    col_c_i       <= row[3];
    col_d_i       <= row[4];
    col_e_i       <= row[5];
    end_of_data_i <= last;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // all expected words out, then let the sequencer settle
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (expected_words.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_stride(input logic [STRIDE_W-1:0] value);
    wait_idle();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  task automatic send_data_set(input int rows, input bit allow_restride);
    for (int i = 0; i < rows; i++) begin
      if (allow_restride && i > 0 && $urandom_range(0, 15) == 0) begin
        write_stride(STRIDE_W'($urandom_range(1, 8)));
      end
      send_row(random_row(), i == rows - 1);
    end
  endtask

  // reset stride, full-range ramps, flush of a bare keyframe
  task automatic test_extreme_ramp();
    send_row(row_of(WORD_MAX, WORD_MIN, WORD_MAX, 0, 32'hFFFF_FFFF, WORD_MIN), 1'b0);
    repeat (3) send_row(random_row(), 1'b0);
    send_row(row_of(WORD_MIN, WORD_MAX, WORD_MIN, 32'hFFFF_FFFF, 0, 1), 1'b0);
    send_row(row_of(1, 2, 3, 4, 5, 6), 1'b1);
  endtask

  // final word with no open segment
  task automatic test_single_row_set();
    send_row(row_of(WORD_MAX, WORD_MAX, WORD_MIN, WORD_MIN, 32'hFFFF_FFFF, 0), 1'b1);
  endtask

  // closing keyframe that also ends the data set
  task automatic test_key_ends_set();
    write_stride(2);
    send_row(row_of(32'h0001_0000, 100, -100, 7, -7, WORD_MAX), 1'b0);
    send_row(random_row(), 1'b0);
    send_row(row_of(32'h0002_0000, -100, 100, -7, 7, WORD_MIN), 1'b1);
  endtask

  // zero stride acts as one
  task automatic test_stride_zero();
    write_stride(0);
    send_row(random_row(), 1'b0);
    send_row(random_row(), 1'b0);
    send_row(random_row(), 1'b1);
  endtask

  // stride above the maximum saturates, short set is flushed
  task automatic test_stride_saturate();
    write_stride(6'd63);
    send_row(random_row(), 1'b0);
    send_row(random_row(), 1'b0);
    send_row(random_row(), 1'b0);
    send_row(random_row(), 1'b1);
  endtask

  // stride lowered under a partly filled segment
  task automatic test_stride_lowered();
    write_stride(8);
    send_row(random_row(), 1'b0);
    repeat (4) send_row(random_row(), 1'b0);
    write_stride(3);
    send_row(random_row(), 1'b0);
    send_row(random_row(), 1'b1);
  endtask

  // random data sets over a range of strides
  task automatic test_random_traffic();
    logic [STRIDE_W-1:0] stride_plan[10] = '{1, 2, 3, 4, 5, 0, 32, 7, 6'd63, 3};
    int sent;
    int rows;
    int eff;
    for (int p = 0; p < 10; p++) begin
      write_stride(stride_plan[p]);
      no_gaps = (p == 2);
      eff = (stride_plan[p] == 0) ? 1 :
            (stride_plan[p] > MAX_STRIDE_DEF) ? MAX_STRIDE_DEF : stride_plan[p];
      if (eff > 8) begin
        send_data_set(eff + 1 + $urandom_range(0, 2), 1'b0);
      end else begin
        sent = 0;
        while (sent < 10) begin
          rows = $urandom_range(1, 2 * eff + 1);
          send_data_set(rows, 1'b1);
          sent += rows;
        end
      end
    end
    no_gaps = 1'b0;
  endtask

  initial begin
    rst_ni        <= 1'b0;
    cfg_we_i      <= 1'b0;
    cfg_wdata_i   <= '0;
    in_valid_i    <= 1'b0;
    col_time_i    <= '0;
    col_a_i       <= '0;
    col_b_i       <= '0;
    col_c_i       <= '0;
    col_d_i       <= '0;
    col_e_i       <= '0;
    end_of_data_i <= 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_extreme_ramp();
    test_single_row_set();
    test_key_ends_set();
    test_stride_zero();
    test_stride_saturate();
    test_stride_lowered();
    test_random_traffic();

    wait_idle();
    if (mismatch_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
